// ----- hw/rtl/sds_pkg.sv -----
package sds_pkg;

    // Widths of the query, the divisor counter and the result.
    localparam int N_W     = 21;
    localparam int D_W     = 11;
    localparam int TOTAL_W = 40;
    localparam int PROD_W  = 2 * N_W;
    localparam int ACC_W   = PROD_W;

    // Largest query served; larger queries are clamped to it.
    localparam logic [N_W-1:0] N_MAX = N_W'(1048576);

    // Largest value the result field can carry.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Quotient bits retired per divider cycle and the resulting cycle count.
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = N_W / DIV_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Multiplier operand selection.
    localparam logic [1:0] MUL_DQ = 2'd0;  // d * q
    localparam logic [1:0] MUL_QQ = 2'd1;  // q * (q + 1)
    localparam logic [1:0] MUL_SS = 2'd2;  // s * (s + 1)
    localparam logic [1:0] MUL_ST = 2'd3;  // s * T(s)

    // Accumulator operations.
    localparam logic [1:0] ACC_NONE     = 2'd0;
    localparam logic [1:0] ACC_ADD      = 2'd1;
    localparam logic [1:0] ACC_ADD_HALF = 2'd2;
    localparam logic [1:0] ACC_SUB      = 2'd3;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic [1:0] acc_op;
        logic       d_inc;
        logic       out_load;
    } sds_cmd_t;

    typedef struct packed {
        logic div_done;
        logic q_lt_d;
    } sds_stat_t;

endpackage

// ----- hw/rtl/sds_div.sv -----
module sds_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sds_pkg::N_W-1:0]      dividend,
    input  logic [sds_pkg::D_W-1:0]      divisor,
    output logic [sds_pkg::N_W-1:0]      quotient,
    output logic                         done
);

    localparam logic [sds_pkg::CNT_W-1:0] CNT_LAST = sds_pkg::CNT_W'(sds_pkg::DIV_STEPS - 1);

    logic [sds_pkg::N_W-1:0] quo_reg;
    logic [sds_pkg::N_W-1:0] quo_next;
    logic [sds_pkg::D_W:0]   rem_reg;
    logic [sds_pkg::D_W:0]   rem_next;
    logic [sds_pkg::D_W-1:0] den_reg;
    logic [sds_pkg::CNT_W-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    // Restoring division, several quotient bits per cycle.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int k = 0; k < sds_pkg::DIV_BITS; k++)
        begin
            rem_next = {rem_next[sds_pkg::D_W-1:0], quo_next[sds_pkg::N_W-1]};
            quo_next = {quo_next[sds_pkg::N_W-2:0], 1'b0};
            if (rem_next >= {1'b0, den_reg})
            begin
                rem_next    = rem_next - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- hw/rtl/sds_datapath.sv -----
module sds_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sds_pkg::sds_cmd_t            cmd,
    output sds_pkg::sds_stat_t           stat,
    input  logic [sds_pkg::N_W-1:0]      n,
    output logic [sds_pkg::TOTAL_W-1:0]  total
);

    localparam int PAD_W = sds_pkg::N_W - sds_pkg::D_W;

    logic [sds_pkg::N_W-1:0]     n_reg;
    logic [sds_pkg::D_W-1:0]     d_reg;
    logic [sds_pkg::ACC_W-1:0]   acc_reg;
    logic [sds_pkg::ACC_W-1:0]   acc_next;
    logic [sds_pkg::PROD_W-1:0]  prod_reg;
    logic [sds_pkg::PROD_W-1:0]  prod_next;
    logic [sds_pkg::TOTAL_W-1:0] total_reg;
    logic [sds_pkg::N_W-1:0]     q;
    logic [sds_pkg::D_W-1:0]     s;
    logic [sds_pkg::N_W-1:0]     mul_a;
    logic [sds_pkg::N_W-1:0]     mul_b;
    logic                        div_done;

    sds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .quotient (q),
        .done     (div_done)
    );

    // s is the last divisor that passed the square-root test.
    assign s = d_reg - 1'b1;

    always_comb
    begin
        unique case (cmd.mul_sel)
            sds_pkg::MUL_DQ:
            begin
                mul_a = {{PAD_W{1'b0}}, d_reg};
                mul_b = q;
            end
            sds_pkg::MUL_QQ:
            begin
                mul_a = q;
                mul_b = q + 1'b1;
            end
            sds_pkg::MUL_SS:
            begin
                mul_a = {{PAD_W{1'b0}}, s};
                mul_b = {{PAD_W{1'b0}}, s + 1'b1};
            end
            default:
            begin
                mul_a = {{PAD_W{1'b0}}, s};
                mul_b = prod_reg[sds_pkg::N_W:1];
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        unique case (cmd.acc_op)
            sds_pkg::ACC_NONE:     acc_next = acc_reg;
            sds_pkg::ACC_ADD:      acc_next = acc_reg + prod_reg;
            sds_pkg::ACC_ADD_HALF: acc_next = acc_reg + {1'b0, prod_reg[sds_pkg::PROD_W-1:1]};
            default:               acc_next = acc_reg - prod_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= (n > sds_pkg::N_MAX) ? sds_pkg::N_MAX : n;
            d_reg   <= sds_pkg::D_W'(1);
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.d_inc)
            begin
                d_reg <= d_reg + 1'b1;
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load)
        begin
            total_reg <= (acc_reg > {{(sds_pkg::ACC_W-sds_pkg::TOTAL_W){1'b0}}, sds_pkg::TOTAL_MAX})
                         ? sds_pkg::TOTAL_MAX : acc_reg[sds_pkg::TOTAL_W-1:0];
        end
    end

    assign stat.div_done = div_done;
    assign stat.q_lt_d   = q < {{PAD_W{1'b0}}, d_reg};
    assign total         = total_reg;

endmodule

// ----- hw/rtl/sds_ctrl.sv -----
module sds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  sds_pkg::sds_stat_t stat,
    output sds_pkg::sds_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_WAIT  = 4'd2;
    localparam logic [3:0] S_MUL_A = 4'd3;
    localparam logic [3:0] S_MUL_B = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_FIN_A = 4'd6;
    localparam logic [3:0] S_FIN_B = 4'd7;
    localparam logic [3:0] S_FIN_C = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = sds_pkg::MUL_DQ;
        cmd.acc_op  = sds_pkg::ACC_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.q_lt_d ? S_FIN_A : S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sds_pkg::MUL_DQ;
                state_next  = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sds_pkg::MUL_QQ;
                cmd.acc_op  = sds_pkg::ACC_ADD;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_op = sds_pkg::ACC_ADD_HALF;
                cmd.d_inc  = 1'b1;
                state_next = S_START;
            end
            S_FIN_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sds_pkg::MUL_SS;
                state_next  = S_FIN_B;
            end
            S_FIN_B:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sds_pkg::MUL_ST;
                state_next  = S_FIN_C;
            end
            S_FIN_C:
            begin
                cmd.acc_op = sds_pkg::ACC_SUB;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- hw/rtl/summatory_divisor_sum_top.sv -----
// Throughput: one query at a time; each divisor step runs the divider (3 quotient bits per
// cycle), then the shared multiplier and accumulator steps.
// Reset: rst_n is asynchronous, active low; it idles the controller and empties the output.
module summatory_divisor_sum_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [sds_pkg::N_W-1:0]      n,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [sds_pkg::TOTAL_W-1:0]  total
);

    // The sum of sigma(i) for i up to n equals the sum over d of d * floor(n / d).
    // The hyperbola method splits that sum at s = floor(sqrt(n)):
    //     total = sum over d <= s of ( d * q + q * (q + 1) / 2 ) - s * s * (s + 1) / 2
    // with q = floor(n / d). The loop runs d upward and stops at the first d with q < d,
    // which is exactly the first d above s, so no square root is ever formed.
    //
    // Each loop step runs one division in the iterative divider, then two products in the
    // single shared multiplier, each added into a wide accumulator the following cycle. The
    // correction term takes two more products and one subtraction. The accumulator is two
    // bits wider than the result so that the partial sum before the correction never wraps.
    //
    // The result lands in an output register, so a finished word may sit there while the
    // next query word is already accepted and worked on.

    sds_pkg::sds_cmd_t  cmd;
    sds_pkg::sds_stat_t stat;

    sds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sds_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .n     (n),
        .total (total)
    );

    // Once a query word is taken, the block stays busy until its result is produced.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("query accepted but block did not go busy");

    // Loading the output register always presents a valid result word next cycle.
    a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp_valid)
        else $error("result loaded but not presented");

    // The divider reports completion for a single cycle per division.
    a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |=> !stat.div_done)
        else $error("divider done held for more than one cycle");

endmodule
